FILE: src/srd_pkg.sv
// Shared types, constants and the magic header table for the session record deframer.
`default_nettype none
package srd_pkg;

    localparam int HANDSHAKE_BYTES = 40;
    localparam int MAGIC_LEN       = 12;
    localparam int NAME_LEN_FIRST  = 36;
    localparam int NAME_LEN_END    = 40;
    localparam int HS_W            = 6;
    localparam int FC_W            = 4;

    localparam logic [2:0] KIND_PAYLOAD   = 3'd0;
    localparam logic [2:0] KIND_HANDSHAKE = 3'd1;
    localparam logic [2:0] KIND_NAME      = 3'd2;
    localparam logic [2:0] KIND_BAD_MAGIC = 3'd3;
    localparam logic [2:0] KIND_NAME_ERR  = 3'd4;

    typedef enum logic [2:0] {
        PH_MAGIC = 3'd0,
        PH_LEN   = 3'd1,
        PH_DATA  = 3'd2,
        PH_NAME  = 3'd3,
        PH_PAD   = 3'd4,
        PH_TS    = 3'd5,
        PH_ERR   = 3'd6
    } t_phase;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [2:0] kind;
        logic       record_last;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [FC_W-1:0] idx);
        logic [7:0] b;
        unique case (idx)
            4'd0:    b = 8'h46;
            4'd1:    b = 8'h42;
            4'd2:    b = 8'h53;
            4'd3:    b = 8'h20;
            4'd4:    b = 8'h30;
            4'd5:    b = 8'h30;
            4'd6:    b = 8'h31;
            4'd7:    b = 8'h2E;
            4'd8:    b = 8'h30;
            4'd9:    b = 8'h30;
            4'd10:   b = 8'h30;
            4'd11:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: src/srd_step.sv
// Parser state and per-item next-state logic of the session record deframer.
`default_nettype none
module srd_step
    import srd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire logic [7:0] i_byte,
    output logic            o_res_valid,
    output t_result         o_res
);

    t_phase            r_phase, n_phase;
    logic [FC_W-1:0]   r_fc, n_fc;
    logic [31:0]       r_len, n_len;
    logic [31:0]       r_data_left, n_data_left;
    logic [1:0]        r_pad_left, n_pad_left;
    logic [HS_W-1:0]   r_hs_left, n_hs_left;
    logic [31:0]       r_name_len, n_name_len;

    logic [FC_W-1:0]   magic_idx;
    logic [FC_W-1:0]   fc_inc;
    logic [31:0]       len_shift;
    logic [HS_W-1:0]   hs_idx;
    logic [31:0]       dl_dec;
    logic              data_end;
    t_phase            end_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_MAGIC;
            r_fc        <= '0;
            r_len       <= '0;
            r_data_left <= '0;
            r_pad_left  <= '0;
            r_hs_left   <= HS_W'(HANDSHAKE_BYTES);
            r_name_len  <= '0;
        end else if (i_valid) begin
            r_phase     <= n_phase;
            r_fc        <= n_fc;
            r_len       <= n_len;
            r_data_left <= n_data_left;
            r_pad_left  <= n_pad_left;
            r_hs_left   <= n_hs_left;
            r_name_len  <= n_name_len;
        end
    end

    always_comb begin
        magic_idx = (r_fc >= FC_W'(MAGIC_LEN)) ? '0 : r_fc;
        fc_inc    = r_fc + FC_W'(1);
        len_shift = {r_len[23:0], i_byte};
        hs_idx    = HS_W'(HANDSHAKE_BYTES) - r_hs_left;
        dl_dec    = (r_data_left != '0) ? (r_data_left - 32'd1) : r_data_left;
        data_end  = (dl_dec == '0);
        end_phase = (r_pad_left != '0) ? PH_PAD : PH_TS;

        n_phase     = r_phase;
        n_fc        = r_fc;
        n_len       = r_len;
        n_data_left = r_data_left;
        n_pad_left  = r_pad_left;
        n_hs_left   = r_hs_left;
        n_name_len  = r_name_len;
        o_res_valid = 1'b0;
        o_res       = '{out_byte: i_byte, kind: KIND_PAYLOAD, record_last: data_end};

        unique case (r_phase)
            PH_MAGIC: begin
                if (i_byte != magic_byte(magic_idx)) begin
                    o_res_valid = 1'b1;
                    o_res       = '{out_byte: 8'h00, kind: KIND_BAD_MAGIC, record_last: 1'b0};
                    n_phase     = PH_ERR;
                    n_fc        = magic_idx;
                end else if (magic_idx == FC_W'(MAGIC_LEN - 1)) begin
                    n_fc    = '0;
                    n_len   = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_fc = magic_idx + FC_W'(1);
                end
            end
            PH_LEN: begin
                n_len = len_shift;
                n_fc  = fc_inc;
                if (fc_inc >= FC_W'(4)) begin
                    n_data_left = len_shift;
                    n_pad_left  = 2'(3'd4 - {1'b0, len_shift[1:0]});
                    n_fc        = '0;
                    if (len_shift != '0) begin
                        n_phase = PH_DATA;
                    end else begin
                        n_phase = (n_pad_left != '0) ? PH_PAD : PH_TS;
                    end
                end
            end
            PH_DATA, PH_NAME: begin
                o_res_valid = 1'b1;
                n_data_left = dl_dec;
                if (data_end) begin
                    n_fc    = '0;
                    n_phase = end_phase;
                end
                if (r_phase == PH_NAME) begin
                    o_res.kind = KIND_NAME;
                end else if (r_hs_left != '0) begin
                    o_res.kind = KIND_HANDSHAKE;
                    n_hs_left  = r_hs_left - HS_W'(1);
                    if (hs_idx >= HS_W'(NAME_LEN_FIRST) && hs_idx < HS_W'(NAME_LEN_END)) begin
                        n_name_len = {r_name_len[23:0], i_byte};
                    end
                end else if (r_name_len != '0) begin
                    if (r_data_left != r_name_len) begin
                        o_res       = '{out_byte: 8'h00, kind: KIND_NAME_ERR, record_last: 1'b0};
                        n_data_left = r_data_left;
                        n_fc        = r_fc;
                        n_phase     = PH_ERR;
                    end else begin
                        o_res.kind = KIND_NAME;
                        n_name_len = '0;
                        if (!data_end) begin
                            n_phase = PH_NAME;
                        end
                    end
                end
            end
            PH_PAD: begin
                n_pad_left = (r_pad_left != '0) ? (r_pad_left - 2'd1) : r_pad_left;
                if (n_pad_left == '0) begin
                    n_fc    = '0;
                    n_phase = PH_TS;
                end
            end
            PH_TS: begin
                n_fc = fc_inc;
                if (fc_inc >= FC_W'(4)) begin
                    n_fc    = '0;
                    n_len   = '0;
                    n_phase = PH_LEN;
                end
            end
            default: begin
                n_phase = PH_ERR;
            end
        endcase
    end

endmodule
`default_nettype wire

FILE: src/srd_out_buf.sv
// Two-entry result buffer that decouples the parser from the output handshake.
`default_nettype none
module srd_out_buf
    import srd_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_wr,
    input  t_result      i_res,
    output logic         o_room,
    output logic         o_valid,
    input  wire logic    i_ready,
    output t_result      o_res
);

    t_result     r_buf [0:1];
    logic        r_wr_ptr, n_wr_ptr;
    logic        r_rd_ptr, n_rd_ptr;
    logic [1:0]  r_count, n_count;
    logic        pop;

    always_comb begin
        pop      = (r_count != 2'd0) && i_ready;
        n_wr_ptr = r_wr_ptr ^ i_wr;
        n_rd_ptr = r_rd_ptr ^ pop;
        n_count  = r_count + 2'(i_wr) - 2'(pop);
        o_room   = (r_count != 2'd2);
        o_valid  = (r_count != 2'd0);
        o_res    = r_buf[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_buf[r_wr_ptr] <= i_res;
        end
    end

endmodule
`default_nettype wire

FILE: src/session_record_deframer.sv
// Top level of the session record deframer: input register, parser and result buffer.
//
// Channel | Direction | tdata            | tuser     | tlast
// s       | in        | [7:0] in_byte    | -         | -
// m       | out       | [7:0] out_byte   | [2:0] kind| record_last
//
// One item per cycle sustained while the result buffer has room; a result is offered on the m side
// once its byte has passed the input register and been written into the result buffer.
// The parser state updates once per byte between the input register and the result buffer.
// Reset is synchronous, active low, and returns the parser to the magic header check.
// A stalled output fills the two-entry result buffer, then the input register, then
// deasserts o_s_tready; no item is dropped.
`default_nettype none
module session_record_deframer
    import srd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [7:0] i_s_tdata,   // [7:0] in_byte
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [7:0]      o_m_tdata,   // [7:0] out_byte
    output logic [2:0]      o_m_tuser,   // [2:0] kind
    output logic            o_m_tlast    // record_last
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        room;
    logic        advance;
    logic        res_valid;
    t_result     res;
    t_result     out_res;

    assign advance    = r_in_valid && room;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    srd_step u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (advance),
        .i_byte      (r_in_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    srd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (advance && res_valid),
        .i_res   (res),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_res   (out_res)
    );

    assign o_m_tdata = out_res.out_byte;
    assign o_m_tuser = out_res.kind;
    assign o_m_tlast = out_res.record_last;

endmodule
`default_nettype wire

FILE: tb/tb_session_record_deframer.sv
// Self-checking testbench for the session record deframer: random recorded files, stalls, scoreboard.
`default_nettype none
module tb_session_record_deframer
    import srd_pkg::*;
();

    localparam int          CLK_HALF   = 2;
    localparam int          CYCLE_CAP  = 100000;
    localparam int          FILE_BYTES = 550;
    localparam int          TAIL_BYTES = 64;
    localparam int          PRINT_CAP  = 25;
    localparam logic [95:0] FILE_HDR   = "FBS 001.000\n";

    typedef enum int {
        RUN_BAD_MAGIC,
        RUN_NAME_ERR,
        RUN_NO_NAME,
        RUN_NAMED
    } t_run;

    logic       i_clk    = 1'b0;
    logic       i_rst_n  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata  = 8'h00;
    logic       m_tready = 1'b0;
    logic       o_s_tready;
    logic       o_m_tvalid;
    logic [7:0] o_m_tdata;
    logic [2:0] o_m_tuser;
    logic       o_m_tlast;

    session_record_deframer dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #CLK_HALF i_clk = ~i_clk;

    logic [7:0] file_bytes[$];
    logic [7:0] rec_body[$];
    t_result    deframed_q[$];
    int         mismatch_count = 0;
    int         accepted       = 0;
    int         cycles         = 0;
    int         in_gap         = 0;
    int         out_stall      = 0;
    logic       calm           = 1'b0;

    // deframer state as seen by the scoreboard
    t_phase      pr_phase     = PH_MAGIC;
    logic [3:0]  pr_cnt       = '0;
    logic [31:0] pr_len_acc   = '0;
    logic [31:0] pr_remain    = '0;
    logic [1:0]  pr_pad       = '0;
    logic [5:0]  pr_hs_left   = HANDSHAKE_BYTES[5:0];
    logic [31:0] pr_name_len  = '0;

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < PRINT_CAP) $display("mismatch at cycle %0d: %s", cycles, msg);
        mismatch_count++;
    endtask

    task automatic close_data();
        pr_cnt   = '0;
        pr_phase = (pr_pad != 2'd0) ? PH_PAD : PH_TS;
    endtask

    task automatic emit_data(input logic [7:0] b, input logic [2:0] k);
        t_result r;
        r.out_byte    = b;
        r.kind        = k;
        r.record_last = 1'b0;
        if (pr_remain != 0) pr_remain--;
        if (pr_remain == 0) begin
            r.record_last = 1'b1;
            close_data();
        end
        deframed_q.push_back(r);
    endtask

    task automatic emit_error(input logic [2:0] k);
        t_result r;
        r.out_byte    = 8'h00;
        r.kind        = k;
        r.record_last = 1'b0;
        pr_phase      = PH_ERR;
        deframed_q.push_back(r);
    endtask

    task automatic deframe_byte(input logic [7:0] b);
        int hs_idx;
        case (pr_phase)
            PH_MAGIC: begin
                if (b != FILE_HDR[8*(MAGIC_LEN-1-pr_cnt) +: 8]) begin
                    emit_error(KIND_BAD_MAGIC);
                end else if (pr_cnt == MAGIC_LEN - 1) begin
                    pr_cnt     = '0;
                    pr_len_acc = '0;
                    pr_phase   = PH_LEN;
                end else begin
                    pr_cnt++;
                end
            end
            PH_LEN: begin
                pr_len_acc = {pr_len_acc[23:0], b};
                pr_cnt++;
                if (pr_cnt == 4'd4) begin
                    pr_remain = pr_len_acc;
                    pr_pad    = 2'd0 - pr_len_acc[1:0];
                    pr_cnt    = '0;
                    if (pr_remain != 0) pr_phase = PH_DATA;
                    else close_data();
                end
            end
            PH_DATA: begin
                if (pr_hs_left != 0) begin
                    hs_idx = HANDSHAKE_BYTES - int'(pr_hs_left);
                    if (hs_idx >= NAME_LEN_FIRST) pr_name_len = {pr_name_len[23:0], b};
                    pr_hs_left--;
                    emit_data(b, KIND_HANDSHAKE);
                end else if (pr_name_len != 0) begin
                    if (pr_remain != pr_name_len) begin
                        emit_error(KIND_NAME_ERR);
                    end else begin
                        pr_name_len = '0;
                        pr_phase    = PH_NAME;
                        emit_data(b, KIND_NAME);
                    end
                end else begin
                    emit_data(b, KIND_PAYLOAD);
                end
            end
            PH_NAME: emit_data(b, KIND_NAME);
            PH_PAD: begin
                if (pr_pad != 0) pr_pad--;
                if (pr_pad == 0) begin
                    pr_cnt   = '0;
                    pr_phase = PH_TS;
                end
            end
            PH_TS: begin
                pr_cnt++;
                if (pr_cnt == 4'd4) begin
                    pr_cnt     = '0;
                    pr_len_acc = '0;
                    pr_phase   = PH_LEN;
                end
            end
            default: ;
        endcase
    endtask

    task automatic push_be32(input logic [31:0] v);
        for (int i = 3; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
    endtask

    task automatic add_record(input int len);
        push_be32(len);
        for (int i = 0; i < len; i++) begin
            if (rec_body.size() != 0) file_bytes.push_back(rec_body.pop_front());
            else file_bytes.push_back(8'($urandom_range(0, 255)));
        end
        repeat ((4 - len % 4) % 4) file_bytes.push_back(8'($urandom_range(0, 255)));
        repeat (4) file_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && o_s_tready) begin
                deframe_byte(s_tdata);
                accepted++;
                if (accepted % 50 == 0) calm <= ($urandom_range(0, 2) == 0);
            end
            if (!s_tvalid || o_s_tready) begin
                if (in_gap != 0) begin
                    in_gap   <= in_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (file_bytes.size() != 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= file_bytes.pop_front();
                    if (!calm && file_bytes.size() > TAIL_BYTES && $urandom_range(0, 4) == 0)
                        in_gap <= $urandom_range(1, 9);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : watch_output
        t_result want;
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && m_tready) begin
                if (deframed_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected item byte %h kind %0d last %b",
                                            o_m_tdata, o_m_tuser, o_m_tlast));
                end else begin
                    want = deframed_q.pop_front();
                    if (o_m_tdata !== want.out_byte)
                        flag_mismatch($sformatf("byte %h, want %h", o_m_tdata, want.out_byte));
                    if (o_m_tuser !== want.kind)
                        flag_mismatch($sformatf("kind %0d, want %0d", o_m_tuser, want.kind));
                    if (o_m_tlast !== want.record_last)
                        flag_mismatch($sformatf("last %b, want %b", o_m_tlast, want.record_last));
                end
            end
            if (out_stall != 0) begin
                out_stall <= out_stall - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (!calm && file_bytes.size() > TAIL_BYTES && $urandom_range(0, 4) == 0)
                    out_stall <= $urandom_range(1, 9);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_CAP) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        t_run        run;
        int          k;
        int          pos;
        int          sz;
        int          total;
        int          extra;
        logic [31:0] name_len;
        logic [31:0] big_len;
        logic        merged;

        case ($urandom_range(0, 9))
            0:       run = RUN_BAD_MAGIC;
            1:       run = RUN_NAME_ERR;
            2, 3:    run = RUN_NO_NAME;
            default: run = RUN_NAMED;
        endcase

        if (run == RUN_BAD_MAGIC) begin
            k = $urandom_range(0, MAGIC_LEN - 1);
            for (int i = 0; i < k; i++) file_bytes.push_back(FILE_HDR[8*(MAGIC_LEN-1-i) +: 8]);
            file_bytes.push_back(FILE_HDR[8*(MAGIC_LEN-1-k) +: 8] ^ 8'($urandom_range(1, 255)));
            while (file_bytes.size() < FILE_BYTES)
                file_bytes.push_back(8'($urandom_range(0, 255)));
        end else begin
            for (int i = 0; i < MAGIC_LEN; i++)
                file_bytes.push_back(FILE_HDR[8*(MAGIC_LEN-1-i) +: 8]);
            case (run)
                RUN_NAMED: begin
                    name_len = $urandom_range(1, 24);
                    extra    = name_len;
                end
                RUN_NO_NAME: begin
                    name_len = '0;
                    extra    = $urandom_range(0, 12);
                end
                default: begin
                    if ($urandom_range(0, 1) != 0) name_len = $urandom | 32'h1;
                    else name_len = $urandom_range(1, 24);
                    extra = $urandom_range(1, 24);
                    if (extra == name_len) extra++;
                end
            endcase
            merged = 1'($urandom_range(0, 1));

            // handshake split across records, optionally sharing its last record
            repeat (NAME_LEN_FIRST) rec_body.push_back(8'($urandom_range(0, 255)));
            push_be32(name_len);
            for (int i = 0; i < 4; i++) rec_body.push_back(file_bytes.pop_back());
            for (int i = 0; i < 2; i++) begin
                k = rec_body[NAME_LEN_FIRST + i];
                rec_body[NAME_LEN_FIRST + i] = rec_body[NAME_LEN_END - 1 - i];
                rec_body[NAME_LEN_END - 1 - i] = 8'(k);
            end
            total = merged ? HANDSHAKE_BYTES + extra : HANDSHAKE_BYTES;
            pos = 0;
            while (pos < HANDSHAKE_BYTES) begin
                if ($urandom_range(0, 4) == 0) add_record(0);
                sz = $urandom_range(1, 16);
                if (pos + sz >= HANDSHAKE_BYTES) sz = total - pos;
                add_record(sz);
                pos += sz;
            end
            if (!merged && extra != 0) begin
                if ($urandom_range(0, 1) != 0) add_record(0);
                add_record(extra);
            end

            if (run == RUN_NAME_ERR) begin
                while (file_bytes.size() < FILE_BYTES)
                    file_bytes.push_back(8'($urandom_range(0, 255)));
            end else begin
                add_record(0);
                for (int n = 1; n <= 5; n++) begin
                    for (int i = 0; i < n; i++) rec_body.push_back((i % 2 != 0) ? 8'hFF : 8'h00);
                    add_record(n);
                end
                while (file_bytes.size() < FILE_BYTES) begin
                    if ($urandom_range(0, 9) < 7) add_record($urandom_range(0, 8));
                    else add_record($urandom_range(9, 48));
                end
                // unterminated record with a huge length
                big_len = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
                push_be32(big_len);
                repeat (16) file_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (file_bytes.size() != 0 || s_tvalid || deframed_q.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);

        if (mismatch_count == 0 && deframed_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
